@@ rtl/brp_pkg.sv @@
// Package for the bus remap and protection unit: widths, operation codes and
// the word type passed from the front stage to the back stage. No dependencies.
package brp_pkg;
  localparam int MapEntries  = 32;
  localparam int PageEntries = 1024;
  localparam int PortEntries = 4096;

  typedef enum logic [2:0] {
    OP_MEM_READ  = 3'd0,
    OP_MEM_WRITE = 3'd1,
    OP_IO_READ   = 3'd2,
    OP_IO_WRITE  = 3'd3,
    OP_LOAD_MAP  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    CFG_PROTECTED  = 3'd0,
    CFG_MEM_PROT   = 3'd1,
    CFG_MEM_SETUP  = 3'd2,
    CFG_IO_SETUP   = 3'd3,
    CFG_RD_TRAPS   = 3'd4,
    CFG_WR_TRAPS   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic protected_mode;
    logic mem_protect_on;
    logic mem_setup_on;
    logic io_setup_on;
    logic io_read_traps_on;
    logic io_write_traps_on;
  } cfg_t;

  // classified word from front to back
  typedef struct packed {
    logic        is_mem;
    logic        is_write;
    logic        split;      // io byte split mode
    logic [23:0] addr;       // remapped mem address or io port (even)
    logic [1:0]  lanes;
    logic [15:0] wval;
    logic [15:0] iret;
  } job_t;

  // result word
  typedef struct packed {
    logic [23:0] target_address;
    logic [15:0] data_out;
    logic [1:0]  lane_mask;
    logic        access_enable;
    logic        trap_valid;
    logic [13:0] trap_port;
    logic [7:0]  trap_byte;
    logic        trap_is_read;
    logic        trap_low_only;
    logic        trap_odd_byte;
    logic        last;
  } res_t;
endpackage

@@ rtl/brp_front.sv @@
// Front stage: accepts words, remaps addresses through the region map.
// Depends on brp_pkg.
module brp_front import brp_pkg::*; #(
  parameter int MAP_ENTRIES = MapEntries
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        busy,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [22:0] word_address,
  input  logic [1:0]  lanes,
  input  logic [15:0] write_value,
  input  logic [15:0] io_return,
  input  logic [4:0]  map_slot,
  input  logic [23:0] map_target,
  output logic        look_en,
  output logic [23:0] look_addr,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);
  localparam int MW = $clog2(MAP_ENTRIES);
  logic [23:0]   region_map [MAP_ENTRIES];
  logic [MAP_ENTRIES-1:0] written;
  logic          accept;
  logic [23:0]   baddr, entry, maddr, next_addr;
  logic [MW-1:0] idx;
  logic [1:0]    ln;
  logic          is_mem, is_io;

  assign in_ready = (!job_valid || job_ready) && !busy;
  assign accept   = in_valid && in_ready;
  assign baddr    = {word_address, 1'b0};
  assign idx      = baddr[15+MW-1:15];
  assign entry    = written[idx] ? region_map[idx] : 24'({idx, 15'd0});
  assign maddr    = cfg.protected_mode ? ((baddr & 24'hf07fff) | (entry & 24'h0f8000))
                                       : ((baddr & 24'h007fff) | (entry & 24'hff8000));
  assign ln       = (lanes == 2'd0) ? 2'd1 : lanes;
  assign is_mem   = operation == OP_MEM_READ || operation == OP_MEM_WRITE;
  assign is_io    = operation == OP_IO_READ || operation == OP_IO_WRITE;
  assign next_addr = is_mem ? maddr : {10'd0, word_address[12:0], 1'b0};
  assign look_en   = accept;
  assign look_addr = next_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (accept && operation == OP_LOAD_MAP) begin
      written[map_slot[MW-1:0]] <= 1'b1;
    end
    if (accept && operation == OP_LOAD_MAP) begin
      region_map[map_slot[MW-1:0]] <= map_target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_ready) begin
      job_valid <= in_valid && (is_mem || is_io);
    end
    if (accept) begin
      job.is_mem   <= is_mem;
      job.is_write <= operation == OP_MEM_WRITE || operation == OP_IO_WRITE;
      job.split    <= is_io && !cfg.protected_mode;
      job.addr     <= next_addr;
      job.lanes    <= ln;
      job.wval     <= write_value;
      job.iret     <= io_return;
    end
  end
endmodule

@@ rtl/brp_back.sv @@
// Back stage: protection tables, io byte split and result formatting.
// Depends on brp_pkg.
module brp_back import brp_pkg::*; #(
  parameter int PAGE_ENTRIES = PageEntries,
  parameter int PORT_ENTRIES = PortEntries
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  output logic        busy,
  input  logic        look_en,
  input  logic [23:0] look_addr,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        res
);
  localparam int PW = $clog2(PAGE_ENTRIES);
  localparam int QW = $clog2(PORT_ENTRIES);

  logic          page_protect [PAGE_ENTRIES];
  logic [3:0]    port_protect [PORT_ENTRIES];
  logic [QW:0]   clr_cnt;
  logic          clearing;
  logic          phase, phase_next;
  logic [7:0]    acc, acc_next;
  logic          take, step_done;
  logic [23:0]   a;
  logic          odd;
  logic [23:0]   p;
  logic [3:0]    prot;
  logic          rd, en, trap, pagebit, below;
  logic [7:0]    byte_v;
  res_t          r;
  logic          pw_en, qw_en;
  logic [QW-1:0] qw_idx;
  logic [3:0]    qw_val;
  logic [PW-1:0] pg_ridx, pg_widx;
  logic [QW-1:0] ev_ridx, od_ridx;
  logic          page_q, page_fwd, pg_fv;
  logic [3:0]    prot_e_q, prot_o_q, qw_fv, prot_e, prot_o;
  logic          prot_e_fwd, prot_o_fwd;

  assign clearing = !clr_cnt[QW];
  assign busy     = clearing;
  assign take     = job_valid && !clearing && (!out_valid || out_ready);
  assign a        = job.addr;
  assign rd       = !job.is_write;
  assign odd      = phase || job.lanes == 2'd2;
  assign p        = odd ? (a | 24'd1) : a;
  assign pg_widx  = a[10+PW-1:10];
  assign pg_ridx  = look_addr[10+PW-1:10];
  assign ev_ridx  = {look_addr[QW-1:1], 1'b0};
  assign od_ridx  = {look_addr[QW-1:1], 1'b1};
  assign pagebit  = page_fwd ? pg_fv : page_q;
  assign prot_e   = prot_e_fwd ? qw_fv : prot_e_q;
  assign prot_o   = prot_o_fwd ? qw_fv : prot_o_q;
  assign prot     = odd ? prot_o : prot_e;
  assign below    = a < 24'h100000;

  always_comb begin
    r = '0;
    pw_en = 1'b0;
    qw_en = 1'b0;
    qw_idx = a[QW-1:0];
    qw_val = job.wval[3:0];
    acc_next = acc;
    en = 1'b1;
    trap = 1'b0;
    byte_v = '0;
    step_done = 1'b1;
    phase_next = 1'b0;
    r.last = 1'b1;
    if (job.is_mem) begin
      r.target_address = a;
      r.data_out = job.is_write ? job.wval : 16'd0;
      r.lane_mask = job.lanes;
      if (job.is_write) begin
        if (cfg.mem_protect_on && below && pagebit) begin
          en = 1'b0;
        end else if (cfg.mem_setup_on) begin
          pw_en = 1'b1;
          en = 1'b0;
        end else if (cfg.io_setup_on && (a & 24'hff8000) == 24'h0f8000) begin
          qw_en = 1'b1;
          if (job.lanes == 2'd2) begin
            qw_idx = p[QW-1:0];
            qw_val = job.wval[11:8];
          end
        end
      end
      r.access_enable = en;
    end else if (!job.split) begin
      r.target_address = p;
      r.lane_mask = job.lanes;
      r.access_enable = 1'b1;
      if (rd) begin
        r.data_out = job.iret & {{8{job.lanes[1]}}, {8{job.lanes[0]}}};
      end else begin
        r.data_out = job.wval;
      end
    end else begin
      step_done = !(job.lanes == 2'd3 && !phase);
      phase_next = !step_done;
      r.last = step_done;
      r.target_address = p;
      r.lane_mask = odd ? 2'd2 : 2'd1;
      if (rd) begin
        en = !(cfg.io_read_traps_on && prot[0]);
        byte_v = en ? (odd ? job.iret[15:8] : job.iret[7:0]) : 8'hff;
        trap = cfg.io_read_traps_on && !prot[2];
        if (job.lanes == 2'd3) begin
          r.data_out = phase ? {acc, byte_v} : {byte_v, 8'd0};
          acc_next = byte_v;
        end else if (job.lanes == 2'd2) begin
          r.data_out = {byte_v, 8'd0};
        end else begin
          r.data_out = {8'd0, byte_v};
        end
      end else begin
        byte_v = odd ? job.wval[15:8] : job.wval[7:0];
        en = !(cfg.io_write_traps_on && prot[1]);
        trap = cfg.io_write_traps_on && !prot[2];
        r.data_out = odd ? {byte_v, 8'd0} : {8'd0, byte_v};
      end
      r.access_enable = en;
      if (trap) begin
        r.trap_valid = 1'b1;
        r.trap_port = p[13:0];
        r.trap_byte = byte_v;
        r.trap_is_read = rd;
        r.trap_low_only = job.lanes == 2'd1;
        r.trap_odd_byte = job.lanes == 2'd2;
      end
    end
  end

  assign job_ready = take && step_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (take) begin
        phase <= phase_next;
        acc <= acc_next;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (take) begin
      res <= r;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      page_protect[clr_cnt[PW-1:0]] <= 1'b0;
    end else if (take && pw_en) begin
      page_protect[pg_widx] <= job.wval[0];
    end
    if (look_en) begin
      page_q   <= page_protect[pg_ridx];
      page_fwd <= take && pw_en && pg_widx == pg_ridx;
      pg_fv    <= job.wval[0];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      port_protect[clr_cnt[QW-1:0]] <= 4'd0;
    end else if (take && qw_en) begin
      port_protect[qw_idx] <= qw_val;
    end
    if (look_en) begin
      prot_e_q   <= port_protect[ev_ridx];
      prot_o_q   <= port_protect[od_ridx];
      prot_e_fwd <= take && qw_en && qw_idx == ev_ridx;
      prot_o_fwd <= take && qw_en && qw_idx == od_ridx;
      qw_fv      <= qw_val;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res))
    else $error("result changed under stall");
  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !take) else $error("work during clearing");
  a_phase_last: assert property (@(posedge clk) disable iff (rst)
    take && phase |-> r.last) else $error("second byte not last");
endmodule

@@ rtl/bus_remap_and_protection_unit.sv @@
// Bus remap and protection unit. One word per cycle enters while the back stage
// can take it (no output stall, byte step or clearing pass); memory words and
// protected-mode io words give one result a cycle, word io outside protected
// mode gives two results, set by the back stage byte stepper. After reset a
// clearing pass over all PORT_ENTRIES (4096) entries zeroes the io port table
// and the page table; words wait during it. Protection entries are read as a
// word enters the front register. Map loads give no result. Depends on brp_pkg.
module bus_remap_and_protection_unit import brp_pkg::*; #(
  parameter int MAP_ENTRIES  = MapEntries,
  parameter int PAGE_ENTRIES = PageEntries,
  parameter int PORT_ENTRIES = PortEntries
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [0:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[2:0], word_address[25:3], lanes[27:26], write_value[43:28],
  // io_return[59:44], map_slot[64:60], map_target[88:65], zero fill
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // target_address[23:0], data_out[39:24], lane_mask[41:40], access_enable[42],
  // trap_valid[43], trap_port[57:44], trap_byte[65:58], trap_is_read[66],
  // trap_low_only[67], trap_odd_byte[68], zero fill
  output logic [71:0] m_tdata,
  output logic        m_tlast
);
  cfg_t cfg;
  logic job_valid, job_ready;
  logic look_en, busy;
  logic [23:0] look_addr;
  job_t job;
  res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROTECTED: cfg.protected_mode    <= cfg_data[0];
        CFG_MEM_PROT:  cfg.mem_protect_on    <= cfg_data[0];
        CFG_MEM_SETUP: cfg.mem_setup_on      <= cfg_data[0];
        CFG_IO_SETUP:  cfg.io_setup_on       <= cfg_data[0];
        CFG_RD_TRAPS:  cfg.io_read_traps_on  <= cfg_data[0];
        CFG_WR_TRAPS:  cfg.io_write_traps_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  brp_front #(.MAP_ENTRIES(MAP_ENTRIES)) u_front (
    .clk, .rst, .cfg, .busy,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .operation(s_tdata[2:0]), .word_address(s_tdata[25:3]), .lanes(s_tdata[27:26]),
    .write_value(s_tdata[43:28]), .io_return(s_tdata[59:44]),
    .map_slot(s_tdata[64:60]), .map_target(s_tdata[88:65]),
    .look_en, .look_addr,
    .job_valid, .job_ready, .job
  );

  brp_back #(.PAGE_ENTRIES(PAGE_ENTRIES), .PORT_ENTRIES(PORT_ENTRIES)) u_back (
    .clk, .rst, .cfg, .busy, .look_en, .look_addr,
    .job_valid, .job_ready, .job,
    .out_valid(m_tvalid), .out_ready(m_tready), .res
  );

  assign m_tdata = {3'd0, res.trap_odd_byte, res.trap_low_only, res.trap_is_read,
                    res.trap_byte, res.trap_port, res.trap_valid, res.access_enable,
                    res.lane_mask, res.data_out, res.target_address};
  assign m_tlast = res.last;
endmodule

@@ test/bus_remap_and_protection_unit_checker.sv @@
// Checker for the bus remap and protection unit: watches the config port and both
// streams, predicts each result word and compares it field by field.
// Depends on brp_pkg.
`timescale 1ns / 100ps

module bus_remap_and_protection_unit_checker import brp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [0:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic        m_tlast,
  output int          errors,
  output int          pending,
  output int          results_seen
);
  localparam int QW = $clog2(PortEntries);

  logic [23:0] region_map [MapEntries];
  logic        page_bits [PageEntries];
  logic [3:0]  port_bits [PortEntries];
  cfg_t        mode;
  res_t        pending_results [$];

  assign pending = pending_results.size();

  function automatic logic [23:0] remap(input logic [23:0] a);
    logic [23:0] entry;
    entry = region_map[a[19:15]];
    if (mode.protected_mode) return (a & 24'hf07fff) | (entry & 24'h0f8000);
    return (a & 24'h007fff) | (entry & 24'hff8000);
  endfunction

  task automatic predict_access(input logic [95:0] d);
    logic [2:0]  op;
    logic [22:0] wa;
    logic [1:0]  ln;
    logic [15:0] wv, ir, acc, lm;
    logic [23:0] a, port, p;
    logic [7:0]  b;
    logic [3:0]  prot;
    logic        rd, odd, en, trap;
    int          n;
    res_t        r;
    op = d[2:0];
    wa = d[25:3];
    ln = d[27:26];
    wv = d[43:28];
    ir = d[59:44];
    if (ln == 2'd0) ln = 2'd1;
    case (op)
      OP_MEM_READ, OP_MEM_WRITE: begin
        a = remap({wa, 1'b0});
        en = 1'b1;
        if (op == OP_MEM_WRITE) begin
          if (mode.mem_protect_on && a < 24'h100000 && page_bits[a[19:10]]) begin
            en = 1'b0;
          end else if (mode.mem_setup_on) begin
            page_bits[a[19:10]] = wv[0];
            en = 1'b0;
          end else if (mode.io_setup_on && (a & 24'hff8000) == 24'h0f8000) begin
            if (ln == 2'd2) port_bits[{a[QW-1:1], 1'b1}] = wv[11:8];
            else port_bits[a[QW-1:0]] = wv[3:0];
          end
        end
        r = '0;
        r.target_address = a;
        r.data_out = (op == OP_MEM_WRITE) ? wv : 16'h0;
        r.lane_mask = ln;
        r.access_enable = en;
        r.last = 1'b1;
        pending_results.push_back(r);
      end
      OP_IO_READ, OP_IO_WRITE: begin
        rd = (op == OP_IO_READ);
        port = {10'd0, wa[12:0], 1'b0};
        if (mode.protected_mode) begin
          lm = (ln == 2'd1) ? 16'h00ff : (ln == 2'd2) ? 16'hff00 : 16'hffff;
          r = '0;
          r.target_address = (ln == 2'd2) ? (port | 24'd1) : port;
          r.data_out = rd ? (ir & lm) : wv;
          r.lane_mask = ln;
          r.access_enable = 1'b1;
          r.last = 1'b1;
          pending_results.push_back(r);
        end else begin
          n = (ln == 2'd3) ? 2 : 1;
          acc = '0;
          for (int k = 0; k < n; k++) begin
            p = (k == 0 && ln != 2'd2) ? port : (port | 24'd1);
            odd = p[0];
            prot = port_bits[p[QW-1:0]];
            r = '0;
            if (rd) begin
              en = !(mode.io_read_traps_on && prot[0]);
              b = en ? (odd ? ir[15:8] : ir[7:0]) : 8'hff;
              trap = mode.io_read_traps_on && !prot[2];
              if (ln == 2'd2 || (ln == 2'd3 && k == 0)) acc |= {b, 8'h00};
              else acc |= {8'h00, b};
              r.data_out = acc;
            end else begin
              b = odd ? wv[15:8] : wv[7:0];
              en = !(mode.io_write_traps_on && prot[1]);
              trap = mode.io_write_traps_on && !prot[2];
              r.data_out = odd ? {b, 8'h00} : {8'h00, b};
            end
            r.target_address = p;
            r.lane_mask = odd ? 2'd2 : 2'd1;
            r.access_enable = en;
            if (trap) begin
              r.trap_valid = 1'b1;
              r.trap_port = p[13:0];
              r.trap_byte = b;
              r.trap_is_read = rd;
              r.trap_low_only = (ln == 2'd1);
              r.trap_odd_byte = (ln == 2'd2);
            end
            r.last = (k == n - 1);
            pending_results.push_back(r);
          end
        end
      end
      OP_LOAD_MAP: region_map[d[64:60]] = d[88:65];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_result();
    res_t e;
    if (pending_results.size() == 0) begin
      $error("result word 0x%0h with no expectation", m_tdata);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    check_field("target_address", e.target_address, m_tdata[23:0]);
    check_field("data_out", e.data_out, m_tdata[39:24]);
    check_field("lane_mask", e.lane_mask, m_tdata[41:40]);
    check_field("access_enable", e.access_enable, m_tdata[42]);
    check_field("trap_valid", e.trap_valid, m_tdata[43]);
    check_field("trap_port", e.trap_port, m_tdata[57:44]);
    check_field("trap_byte", e.trap_byte, m_tdata[65:58]);
    check_field("trap_is_read", e.trap_is_read, m_tdata[66]);
    check_field("trap_low_only", e.trap_low_only, m_tdata[67]);
    check_field("trap_odd_byte", e.trap_odd_byte, m_tdata[68]);
    check_field("last", e.last, m_tlast);
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MapEntries; i++) region_map[i] = 24'(i * 32768);
      for (int i = 0; i < PageEntries; i++) page_bits[i] = 1'b0;
      for (int i = 0; i < PortEntries; i++) port_bits[i] = 4'd0;
      mode = '0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROTECTED: mode.protected_mode = cfg_data[0];
          CFG_MEM_PROT:  mode.mem_protect_on = cfg_data[0];
          CFG_MEM_SETUP: mode.mem_setup_on = cfg_data[0];
          CFG_IO_SETUP:  mode.io_setup_on = cfg_data[0];
          CFG_RD_TRAPS:  mode.io_read_traps_on = cfg_data[0];
          CFG_WR_TRAPS:  mode.io_write_traps_on = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_access(s_tdata);
      if (m_tvalid && m_tready) begin
        results_seen++;
        check_result();
      end
    end
  end
endmodule

@@ test/bus_remap_and_protection_unit_test.sv @@
// Testbench top for the bus remap and protection unit: clock, reset, stimulus,
// stalls and verdict. Depends on brp_pkg, the unit and its checker.
`timescale 1ns / 100ps

module bus_remap_and_protection_unit_test;
  import brp_pkg::*;

  localparam int IdleLimit = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [0:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;
  int          errors, pending, results_seen;
  int          words_sent = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;

  bus_remap_and_protection_unit i_dut (.*);

  bus_remap_and_protection_unit_checker i_checker (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    int r;
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        m_tready = 1'b1;
        stall_left = $urandom_range(1, 20);
      end else if (r < 95) begin
        m_tready = 1'b0;
        stall_left = $urandom_range(1, 3);
      end else begin
        m_tready = 1'b0;
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
        $display("FAIL bus_remap_and_protection_unit");
        $finish;
      end
    end
  end

  function automatic logic [95:0] pack_word(input logic [2:0] op, input logic [22:0] wa,
      input logic [1:0] ln, input logic [15:0] wv, input logic [15:0] ir,
      input logic [4:0] slot, input logic [23:0] tgt);
    return {7'd0, tgt, slot, ir, wv, ln, wa, op};
  endfunction

  task automatic send_word(input logic [95:0] w);
    int r, gap;
    r = $urandom_range(0, 99);
    gap = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = w;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_modes(input logic [5:0] bits);
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_we = 1'b1;
      cfg_index = i[2:0];
      cfg_data = bits[i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  task automatic send_random();
    int r;
    logic [2:0]  op;
    logic [22:0] wa;
    logic [4:0]  slot;
    logic [23:0] tgt;
    r = $urandom_range(0, 99);
    wa = 23'($urandom_range(0, 23'h7fffff));
    slot = 5'($urandom_range(0, 31));
    tgt = 24'($urandom_range(0, 24'hffffff));
    if (r < 22) begin
      op = OP_MEM_READ;
      if ($urandom_range(0, 1)) wa = {4'd0, 4'($urandom_range(0, 15)), 6'd0, 9'($urandom())};
    end else if (r < 48) begin
      op = OP_MEM_WRITE;
      case ($urandom_range(0, 3))
        0: ;
        1: wa = 23'h07c000 | 23'($urandom_range(0, 63));
        default: wa = {4'd0, 4'($urandom_range(0, 15)), 6'd0, 9'($urandom())};
      endcase
    end else if (r < 92) begin
      op = (r < 70) ? OP_IO_READ : OP_IO_WRITE;
      if ($urandom_range(0, 9) != 0) wa = 23'($urandom_range(0, 63));
    end else if (r < 96) begin
      op = OP_LOAD_MAP;
      if ($urandom_range(0, 9) < 7) tgt = {4'd0, slot, 15'd0};
    end else begin
      op = 3'($urandom_range(5, 7));
    end
    send_word(pack_word(op, wa, 2'($urandom_range(0, 3)), 16'($urandom()),
      16'($urandom()), slot, tgt));
  endtask

  initial begin
    logic [5:0] modes;
    int items;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    send_word(pack_word(OP_MEM_READ, 23'h0, 2'd0, 16'h0, 16'h0, 5'd0, 24'h0));
    send_word(pack_word(OP_MEM_READ, 23'h7fffff, 2'd3, 16'hffff, 16'hffff, 5'd31, 24'hffffff));
    send_word(pack_word(OP_MEM_WRITE, 23'h0, 2'd1, 16'h0, 16'h0, 5'd0, 24'h0));
    send_word(pack_word(OP_MEM_WRITE, 23'h7fffff, 2'd2, 16'hffff, 16'h0, 5'd0, 24'h0));
    for (int ln = 0; ln < 4; ln++) begin
      send_word(pack_word(OP_IO_READ, 23'h1fff, 2'(ln), 16'h0, 16'ha55a, 5'd0, 24'h0));
      send_word(pack_word(OP_IO_WRITE, 23'h0, 2'(ln), 16'hc33c, 16'h0, 5'd0, 24'h0));
    end
    send_word(pack_word(OP_LOAD_MAP, 23'h0, 2'd0, 16'h0, 16'h0, 5'd31, 24'hffffff));
    send_word(pack_word(OP_MEM_READ, 23'h7fffff, 2'd3, 16'h0, 16'h0, 5'd0, 24'h0));
    send_word(pack_word(OP_LOAD_MAP, 23'h0, 2'd0, 16'h0, 16'h0, 5'd31, 24'h0f8000));
    send_word(pack_word(3'd5, 23'h7fffff, 2'd3, 16'hffff, 16'hffff, 5'd31, 24'hffffff));
    send_word(pack_word(3'd7, 23'h0, 2'd0, 16'h0, 16'h0, 5'd0, 24'h0));

    write_modes(6'b000100);
    for (int i = 0; i < 16; i++)
      send_word(pack_word(OP_MEM_WRITE, {4'd0, 4'(i), 15'd0}, 2'd1, 16'($urandom()),
        16'h0, 5'd0, 24'h0));
    write_modes(6'b001000);
    for (int i = 0; i < 64; i++)
      send_word(pack_word(OP_MEM_WRITE, 23'h07c000 | 23'(i), 2'($urandom_range(1, 3)),
        16'($urandom()), 16'h0, 5'd0, 24'h0));
    write_modes(6'b111111);
    write_modes(6'b110010);
    for (int i = 0; i < 64; i++)
      send_word(pack_word(i[0] ? OP_IO_WRITE : OP_IO_READ, 23'(i >> 1), 2'd3,
        16'($urandom()), 16'($urandom()), 5'd0, 24'h0));

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: modes = 6'b000000;
        1: modes = 6'b111111;
        2: modes = 6'b000100;
        3: modes = 6'b001000;
        4: modes = 6'b110010;
        5: modes = 6'b110001;
        default: modes = 6'($urandom_range(0, 63));
      endcase
      write_modes(modes);
      items = 0;
      while (items < 90) begin
        send_random();
        if (s_tdata[2:0] <= OP_LOAD_MAP) items++;
      end
    end
    drain();
    repeat (20) @(negedge clk);

    if (pending != 0) $error("%0d result words never arrived", pending);
    $display("Sent %0d words over 10 random mode phases after directed setup traffic,",
      words_sent);
    $display("checked %0d result words with stalls on both streams.", results_seen);
    if (errors == 0 && pending == 0) begin
      $display("PASS bus_remap_and_protection_unit");
    end else begin
      $display("FAIL bus_remap_and_protection_unit");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/brp_pkg.sv
rtl/brp_front.sv
rtl/brp_back.sv
rtl/bus_remap_and_protection_unit.sv
test/bus_remap_and_protection_unit_checker.sv
test/bus_remap_and_protection_unit_test.sv
